// ----- hw/rtl/b64_pkg.sv -----
// ----------------------------------------------------------------------------
// b64_pkg
// Types, constants and alphabet functions shared by the base64 codec.
// ----------------------------------------------------------------------------
package b64_pkg;

  localparam int unsigned BURST_MAX = 4;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic REG_MODE = 1'b0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       error;
  } out_item_t;

  typedef struct packed {
    out_item_t [BURST_MAX-1:0] items;
    logic [2:0]                count;
  } burst_t;

  function automatic logic [7:0] enc_char(input logic [5:0] s);
    logic [7:0] e;
    logic [7:0] c;
    e = {2'b00, s};
    if (s < 6'd26) begin
      c = e + 8'd65;
    end else if (s < 6'd52) begin
      c = e + 8'd71;
    end else if (s < 6'd62) begin
      c = e - 8'd4;
    end else if (s == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  function automatic logic [5:0] dec_sextet(input logic [7:0] c);
    logic [7:0] s;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s = c - 8'd65;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s = c - 8'd71;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s = c + 8'd4;
    end else if (c == 8'h2B) begin
      s = 8'd62;
    end else if (c == 8'h2F) begin
      s = 8'd63;
    end else begin
      s = 8'd0;
    end
    return s[5:0];
  endfunction

endpackage

// ----- hw/rtl/b64_cfg.sv -----
// ----------------------------------------------------------------------------
// b64_cfg
// APB register file holding the mode bit; flags a group clear on each write to it.
// ----------------------------------------------------------------------------
module b64_cfg import b64_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        mode,
  output logic        clear
);

  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[2] == REG_MODE);
  assign clear  = psel & penable & pwrite & hit;
  assign prdata = hit ? {31'd0, mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ENCODE;
    end else if (clear) begin
      mode <= pwdata[0];
    end
  end

  // low address bits and upper write-data bits are unused
  logic unused_addr;
  assign unused_addr = ^{paddr[1:0], pwdata[31:1]};

endmodule

// ----- hw/rtl/b64_group.sv -----
// ----------------------------------------------------------------------------
// b64_group
// Group gathering state and the single-pass encode/decode of one item.
// ----------------------------------------------------------------------------
module b64_group import b64_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     mode,
  input  logic     clear,
  input  logic     accept,
  input  in_item_t item,
  output burst_t   burst
);

  logic [23:0] acc;
  logic [1:0]  cnt;
  logic [1:0]  pad;
  logic [23:0] acc_next;
  logic [1:0]  cnt_next;
  logic [1:0]  pad_next;

  logic [23:0] acc_in;
  logic [23:0] acc_dec;
  logic [1:0]  cnt_enc;
  logic [1:0]  pad_cur;
  logic [5:0]  sx;
  logic        eq;
  logic [1:0]  npad;
  logic [2:0]  nbytes;
  logic [7:0]  b;
  logic        last;

  always_comb begin
    b        = item.data_byte;
    last     = item.is_last;
    burst    = '0;
    acc_next = acc;
    cnt_next = cnt;
    pad_next = pad;
    acc_in   = acc;
    acc_dec  = acc;
    cnt_enc  = cnt;
    eq       = (b == PAD_CHAR);
    sx       = eq ? 6'd0 : dec_sextet(b);
    pad_cur  = {pad[0], eq};
    npad     = {1'b0, pad_cur[0]} + {1'b0, pad_cur[1]};
    nbytes   = 3'd3;
    if (mode == MODE_ENCODE) begin
      if (cnt == 2'd3) begin
        acc_in  = '0;
        cnt_enc = 2'd0;
      end
      unique case (cnt_enc)
        2'd0:    acc_in[23:16] = b;
        2'd1:    acc_in[15:8]  = b;
        default: acc_in[7:0]   = b;
      endcase
      if (cnt_enc == 2'd2 || last) begin
        burst.count = 3'd4;
        burst.items[0].out_byte = enc_char(acc_in[23:18]);
        burst.items[1].out_byte = enc_char(acc_in[17:12]);
        burst.items[2].out_byte = (cnt_enc == 2'd0) ? PAD_CHAR : enc_char(acc_in[11:6]);
        burst.items[3].out_byte = (cnt_enc != 2'd2) ? PAD_CHAR : enc_char(acc_in[5:0]);
        burst.items[3].out_last = last;
        acc_next = '0;
        cnt_next = 2'd0;
        pad_next = 2'd0;
      end else begin
        acc_next = acc_in;
        cnt_next = cnt_enc + 2'd1;
      end
    end else begin
      unique case (cnt)
        2'd0:    acc_dec[23:18] = acc[23:18] | sx;
        2'd1:    acc_dec[17:12] = acc[17:12] | sx;
        2'd2:    acc_dec[11:6]  = acc[11:6]  | sx;
        default: acc_dec[5:0]   = acc[5:0]   | sx;
      endcase
      if (cnt == 2'd3) begin
        if (last) begin
          nbytes = 3'd3 - {1'b0, npad};
        end
        burst.count = nbytes;
        burst.items[0].out_byte = acc_dec[23:16];
        burst.items[1].out_byte = acc_dec[15:8];
        burst.items[2].out_byte = acc_dec[7:0];
        burst.items[0].out_last = last && nbytes == 3'd1;
        burst.items[1].out_last = last && nbytes == 3'd2;
        burst.items[2].out_last = last && nbytes == 3'd3;
        acc_next = '0;
        cnt_next = 2'd0;
        pad_next = 2'd0;
      end else if (last) begin
        burst.count = 3'd1;
        burst.items[0].out_last = 1'b1;
        burst.items[0].error    = 1'b1;
        acc_next = '0;
        cnt_next = 2'd0;
        pad_next = 2'd0;
      end else begin
        acc_next = acc_dec;
        cnt_next = cnt + 2'd1;
        pad_next = pad_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      acc <= '0;
      cnt <= 2'd0;
      pad <= 2'd0;
    end else if (accept) begin
      acc <= acc_next;
      cnt <= cnt_next;
      pad <= pad_next;
    end
  end

endmodule

// ----- hw/rtl/b64_burst.sv -----
// ----------------------------------------------------------------------------
// b64_burst
// Result buffer: holds the results of one item and sends them one per cycle while result_stall is low.
// ----------------------------------------------------------------------------
module b64_burst import b64_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  burst_t    burst,
  output logic      room,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  out_item_t [BURST_MAX-1:0] items;
  logic [2:0] remain;
  logic [1:0] idx;
  logic       take;

  assign result_valid = (remain != 3'd0);
  assign result       = items[idx];
  assign take         = result_valid & ~result_stall;
  assign room         = (remain == 3'd0) || (remain == 3'd1 && !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= 3'd0;
      idx    <= 2'd0;
    end else if (load && burst.count != 3'd0) begin
      remain <= burst.count;
      idx    <= 2'd0;
    end else if (take) begin
      remain <= remain - 3'd1;
      idx    <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && burst.count != 3'd0) begin
      items <= burst.items;
    end
  end

endmodule

// ----- hw/rtl/base64_codec.sv -----
// ----------------------------------------------------------------------------
// base64_codec
// Streaming base64 encoder/decoder with an APB mode register.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  item     | item_valid / item_stall    | in_item_t  (data_byte, is_last)
//  result   | result_valid / result_stall| out_item_t (out_byte, out_last, error)
//  apb      | psel, penable, pready      | paddr, pwdata, prdata
//
// An item is accepted while item_valid is high and item_stall is low; its
// results land in the result buffer on that edge and leave one per cycle
// while result_stall is low: 4 per encode group, 1 to 3 per decode group,
// 1 for a bad decode length. item_stall is high while more than one buffered
// result is still pending, or while one is pending and result_stall is high.
// Synchronous reset clears the mode to encode and empties group and buffer.
// ----------------------------------------------------------------------------
module base64_codec import b64_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  in_item_t    item,
  output logic        result_valid,
  input  logic        result_stall,
  output out_item_t   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic   mode;
  logic   clear;
  logic   room;
  logic   accept;
  burst_t burst;

  assign item_stall = ~room;
  assign accept     = item_valid & room;

  b64_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode    (mode),
    .clear   (clear)
  );

  b64_group u_group (
    .clk    (clk),
    .rst    (rst),
    .mode   (mode),
    .clear  (clear),
    .accept (accept),
    .item   (item),
    .burst  (burst)
  );

  b64_burst u_burst (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .burst        (burst),
    .room         (room),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for base64_codec. Bytes and characters are pushed
// through the item channel under random gaps and result stalls. Each accepted
// transaction is run through a behavioral codec that tracks mode, group bits,
// count and padding. The outcome is compared field by field with every result
// transaction. Directed groups cover padding, bad lengths, invalid characters
// and mode writes. Random phases then alternate encode and decode traffic,
// mostly well-formed text with some noise.
// ----------------------------------------------------------------------------
module testbench import b64_pkg::*; ();

  localparam int REG_UNUSED = 1;
  localparam int SETTLE_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  in_item_t    item;
  logic        result_valid;
  logic        result_stall;
  out_item_t   result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  string       b64_alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic        model_mode = MODE_ENCODE;
  logic [23:0] model_acc = '0;
  int          model_cnt = 0;
  logic [1:0]  model_pad = '0;
  out_item_t   b64_out_q[$];

  logic [7:0]  msg_raw[$];
  logic [7:0]  msg_txt[$];

  int          mismatches = 0;
  int          send_gap_max = 13;
  int          stall_gap_max = 13;

  base64_codec dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #2 clk = ~clk;

  function automatic logic [7:0] b64_char(input logic [5:0] s);
    return b64_alphabet[s];
  endfunction

  function automatic logic [5:0] b64_sextet(input logic [7:0] c);
    int i;
    logic [5:0] s;
    s = '0;
    for (i = 0; i < 64; i++) begin
      if (b64_alphabet[i] == c) begin
        s = 6'(i);
      end
    end
    return s;
  endfunction

  task automatic clear_group();
    model_acc = '0;
    model_cnt = 0;
    model_pad = '0;
  endtask

  task automatic predict_b64_out(input in_item_t it);
    out_item_t r;
    logic      eq;
    logic [5:0] sx;
    int        i;
    int        nbytes;
    if (model_mode == MODE_ENCODE) begin
      model_acc = model_acc | (24'(it.data_byte) << (16 - 8 * model_cnt));
      model_cnt++;
      if (model_cnt == 3 || it.is_last) begin
        for (i = 0; i < 4; i++) begin
          r.out_byte = (i <= model_cnt) ? b64_char(model_acc[23 - 6 * i -: 6]) : PAD_CHAR;
          r.out_last = it.is_last && i == 3;
          r.error    = 1'b0;
          b64_out_q.push_back(r);
        end
        clear_group();
      end
    end else begin
      eq = (it.data_byte == PAD_CHAR);
      sx = eq ? 6'd0 : b64_sextet(it.data_byte);
      model_pad = {model_pad[0], eq};
      model_acc = model_acc | (24'(sx) << (18 - 6 * model_cnt));
      model_cnt++;
      if (model_cnt == 4) begin
        nbytes = 3;
        if (it.is_last) begin
          nbytes = nbytes - int'(model_pad[0]) - int'(model_pad[1]);
        end
        for (i = 0; i < nbytes; i++) begin
          r.out_byte = model_acc[23 - 8 * i -: 8];
          r.out_last = it.is_last && i == nbytes - 1;
          r.error    = 1'b0;
          b64_out_q.push_back(r);
        end
        clear_group();
      end else if (it.is_last) begin
        r.out_byte = 8'h00;
        r.out_last = 1'b1;
        r.error    = 1'b1;
        b64_out_q.push_back(r);
        clear_group();
      end
    end
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t mismatch: %s", $time, msg);
    end
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && result_valid && !result_stall) begin
      if (b64_out_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result byte %02h last %0b error %0b",
                                result.out_byte, result.out_last, result.error));
      end else begin
        want = b64_out_q.pop_front();
        if (result.out_byte !== want.out_byte || result.out_last !== want.out_last ||
            result.error !== want.error) begin
          note_mismatch($sformatf("expected byte %02h last %0b error %0b, got %02h %0b %0b",
                                  want.out_byte, want.out_last, want.error,
                                  result.out_byte, result.out_last, result.error));
        end
      end
    end
  end

  initial begin : result_side
    int n;
    result_stall = 1'b0;
    forever begin
      n = (stall_gap_max == 0) ? 0 : $urandom_range(0, stall_gap_max);
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(negedge clk);
        result_stall <= 1'b0;
      end
      do @(posedge clk); while (!(result_valid && !result_stall));
      @(negedge clk);
    end
  end

  task automatic send_item(input logic [7:0] data, input logic last);
    int gap;
    in_item_t it;
    gap = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
    it.data_byte = data;
    it.is_last   = last;
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    predict_b64_out(it);
  endtask

  task automatic send_text(input string s, input logic mark_last);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_item(s[i], mark_last && i == s.len() - 1);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    item_valid <= 1'b0;
    while (b64_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write a register, then read back the mode register
  task automatic write_reg(input int index, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * index);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (index == REG_MODE) begin
      model_mode = value[0];
      clear_group();
    end
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= 3'(4 * REG_MODE);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {31'b0, model_mode}) begin
      note_mismatch($sformatf("mode readback expected %08h, got %08h",
                              {31'b0, model_mode}, prdata));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic encode_text();
    int i;
    int j;
    int n;
    logic [23:0] grp;
    msg_txt.delete();
    for (i = 0; i < msg_raw.size(); i += 3) begin
      n = msg_raw.size() - i;
      if (n > 3) n = 3;
      grp = {msg_raw[i], (n > 1) ? msg_raw[i + 1] : 8'h00, (n > 2) ? msg_raw[i + 2] : 8'h00};
      for (j = 0; j < 4; j++) begin
        msg_txt.push_back((j <= n) ? b64_char(grp[23 - 6 * j -: 6]) : PAD_CHAR);
      end
    end
  endtask

  task automatic test_encode_groups();
    send_text("Man", 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'hFB, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
  endtask

  task automatic test_mode_write();
    drain_results();
    send_item(8'h12, 1'b0);
    drain_results();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_item(8'h34, 1'b0);
    drain_results();
    write_reg(REG_MODE, 32'hFFFF_FFFE);
    send_item(8'h56, 1'b1);
  endtask

  task automatic test_decode_groups();
    drain_results();
    write_reg(REG_MODE, 32'h0000_0001);
    send_text("TWE=", 1'b1);
    send_item(8'hFF, 1'b0);
    send_text("g==", 1'b1);
    send_text("=A=B", 1'b0);
    send_text("x", 1'b1);
  endtask

  task automatic test_random_traffic();
    int phase;
    int sent;
    int len;
    int kind;
    int k;
    logic [31:0] word;
    for (phase = 0; phase < 8; phase++) begin
      drain_results();
      word = $urandom();
      word[0] = phase[0] ? MODE_ENCODE : MODE_DECODE;
      write_reg(REG_MODE, word);
      send_gap_max  = (phase % 3 == 2) ? 0 : 13;
      stall_gap_max = (phase % 4 == 3) ? 0 : 13;
      sent = 0;
      while (sent < 40) begin
        if (model_mode == MODE_ENCODE) begin
          len = $urandom_range(1, 12);
          for (k = 0; k < len; k++) begin
            send_item(8'($urandom_range(0, 255)), k == len - 1 && $urandom_range(0, 5) != 0);
          end
          sent += len;
        end else begin
          kind = $urandom_range(0, 9);
          len = $urandom_range(1, 9);
          msg_raw.delete();
          for (k = 0; k < len; k++) msg_raw.push_back(8'($urandom()));
          encode_text();
          case (kind)
            5, 6: msg_txt[$urandom_range(0, msg_txt.size() - 1)] = 8'($urandom());
            7: begin
              msg_txt.delete();
              for (k = 0; k < len; k++) msg_txt.push_back(8'($urandom()));
            end
            8: repeat ($urandom_range(1, 3)) void'(msg_txt.pop_back());
            9: begin
              for (k = 0; k < msg_txt.size(); k++) begin
                if ($urandom_range(0, 2) == 0) msg_txt[k] = PAD_CHAR;
              end
            end
            default: ;
          endcase
          for (k = 0; k < msg_txt.size(); k++) begin
            send_item(msg_txt[k], k == msg_txt.size() - 1);
          end
          sent += msg_txt.size();
        end
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_encode_groups();
    test_mode_write();
    test_decode_groups();
    test_random_traffic();
    drain_results();
    if (mismatches == 0 && b64_out_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/b64_pkg.sv
hw/rtl/b64_cfg.sv
hw/rtl/b64_group.sv
hw/rtl/b64_burst.sv
hw/rtl/base64_codec.sv
bench/testbench.sv
